// ===== design/urm_pkg.sv =====
// ----------------------------------------------------------------------------
// urm_pkg
// Shared types and constants for the UART register model: command codes,
// register offsets, control and status bit positions, and the request and
// response beat layouts.
// ----------------------------------------------------------------------------
package urm_pkg;

   // Command carried by a request beat
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_HOST  = 2'd3
   } cmd_type;

   // Register offsets in the file
   localparam logic [3:0] ADDR_SR   = 4'd0;
   localparam logic [3:0] ADDR_DR   = 4'd1;
   localparam logic [3:0] ADDR_BRR1 = 4'd2;
   localparam logic [3:0] ADDR_BRR2 = 4'd3;
   localparam logic [3:0] ADDR_CR1  = 4'd4;
   localparam logic [3:0] ADDR_CR2  = 4'd5;

   // Status and control bit positions
   localparam int unsigned SR_TXE_BIT      = 7;
   localparam int unsigned SR_TC_BIT       = 6;
   localparam int unsigned SR_RXNE_BIT     = 5;
   localparam int unsigned CR1_DISABLE_BIT = 5;
   localparam int unsigned CR2_TEN_BIT     = 3;
   localparam int unsigned CR2_REN_BIT     = 2;

   // Prescale counter ceiling
   localparam logic [16:0] PRESCALE_MAX = 17'h1FFFF;

   // Request beat
   typedef struct packed {
      cmd_type    cmd;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic [7:0] tick_cycles;
      logic [7:0] host_byte;
   } req_item_type;

   // Response beat
   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic [7:0] status;
   } rsp_item_type;

endpackage

// ===== design/uart_register_model.sv =====
// ----------------------------------------------------------------------------
// uart_register_model
// UART register model: byte register file, baud prescaler, double-buffered
// transmitter and single-byte receiver driven by tick, bus and host beats.
// ----------------------------------------------------------------------------
// Every request beat yields exactly one response beat, in order. A beat is
// captured in an input register, applied to the register file and frame
// state by combinational logic, and its response lands in an output register,
// where rsp_valid rises. A new beat can be taken every cycle while the output
// is not stalled. The only limit on rate is rsp_stall; while the output
// register is stalled, the input register holds and req_stall rises.
module uart_register_model import urm_pkg::*; #(
   parameter int FRAME_BITS = 10,
   parameter int REG_COUNT  = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_payload
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic         advance;
   logic         req_take;
   rsp_item_type step_result;

   // Move the held beat forward when the output register frees up
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   urm_engine #(
      .FRAME_BITS (FRAME_BITS),
      .REG_COUNT  (REG_COUNT)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_valid  (advance),
      .step_item   (in_item_ff),
      .step_result (step_result)
   );

   // Control flops
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload flops
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

// ===== design/urm_engine.sv =====
// ----------------------------------------------------------------------------
// urm_engine
// Register file and UART frame state. Applies one request beat per cycle
// when step_valid is high and presents the matching response combinationally.
// ----------------------------------------------------------------------------
module urm_engine import urm_pkg::*; #(
   parameter int FRAME_BITS = 10,
   parameter int REG_COUNT  = 12
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         step_valid,
   input  req_item_type step_item,
   output rsp_item_type step_result
);

   localparam int ADDR_W = $clog2(REG_COUNT);
   localparam logic [7:0] FRAME_LIMIT = 8'(FRAME_BITS);
   localparam logic [4:0] REG_LIMIT   = 5'(REG_COUNT);

   localparam logic [ADDR_W-1:0] SR_IDX   = ADDR_W'(ADDR_SR);
   localparam logic [ADDR_W-1:0] DR_IDX   = ADDR_W'(ADDR_DR);
   localparam logic [ADDR_W-1:0] BRR1_IDX = ADDR_W'(ADDR_BRR1);
   localparam logic [ADDR_W-1:0] BRR2_IDX = ADDR_W'(ADDR_BRR2);
   localparam logic [ADDR_W-1:0] CR1_IDX  = ADDR_W'(ADDR_CR1);
   localparam logic [ADDR_W-1:0] CR2_IDX  = ADDR_W'(ADDR_CR2);

   logic [7:0]  regfile_ff [REG_COUNT];
   logic [7:0]  regfile_in [REG_COUNT];
   logic [15:0] divisor_ff, divisor_in;
   logic [16:0] prescale_ff, prescale_in;
   logic        enabled_ff, enabled_in;
   logic        tx_en_ff, tx_en_in;
   logic        rx_en_ff, rx_en_in;
   logic [7:0]  tx_cnt_ff, tx_cnt_in;
   logic [7:0]  rx_cnt_ff, rx_cnt_in;
   logic        tx_busy_ff, tx_busy_in;
   logic        rx_busy_ff, rx_busy_in;
   logic        tx_full_ff, tx_full_in;
   logic [7:0]  tx_buf_ff, tx_buf_in;
   logic [7:0]  tx_shift_ff, tx_shift_in;
   logic        host_pend_ff, host_pend_in;
   logic [7:0]  host_byte_ff, host_byte_in;

   logic              addr_hit;
   logic [ADDR_W-1:0] addr_idx;
   logic [17:0]       sum_raw;
   logic [16:0]       sum_sat;
   logic              bit_done;
   logic [7:0]        tx_cnt_v;
   logic [7:0]        rx_cnt_v;
   logic              rx_busy_v;
   logic [7:0]        baud_lo;
   logic [7:0]        baud_hi;
   logic [7:0]        ctrl1;
   logic [7:0]        ctrl2;

   // Decode address and run the prescaler sum
   assign addr_hit = {1'b0, step_item.reg_addr} < REG_LIMIT;
   assign addr_idx = step_item.reg_addr[ADDR_W-1:0];
   assign sum_raw  = {1'b0, prescale_ff} + {10'd0, step_item.tick_cycles};
   assign sum_sat  = sum_raw[17] ? PRESCALE_MAX : sum_raw[16:0];
   assign bit_done = sum_sat >= {1'b0, divisor_ff};

   // Next state and response for one beat
   always_comb begin
      regfile_in   = regfile_ff;
      divisor_in   = divisor_ff;
      prescale_in  = prescale_ff;
      enabled_in   = enabled_ff;
      tx_en_in     = tx_en_ff;
      rx_en_in     = rx_en_ff;
      tx_cnt_in    = tx_cnt_ff;
      rx_cnt_in    = rx_cnt_ff;
      tx_busy_in   = tx_busy_ff;
      rx_busy_in   = rx_busy_ff;
      tx_full_in   = tx_full_ff;
      tx_buf_in    = tx_buf_ff;
      tx_shift_in  = tx_shift_ff;
      host_pend_in = host_pend_ff;
      host_byte_in = host_byte_ff;
      tx_cnt_v     = tx_cnt_ff;
      rx_cnt_v     = rx_cnt_ff;
      rx_busy_v    = rx_busy_ff;
      baud_lo      = regfile_ff[BRR1_IDX];
      baud_hi      = regfile_ff[BRR2_IDX];
      ctrl1        = regfile_ff[CR1_IDX];
      ctrl2        = regfile_ff[CR2_IDX];
      step_result  = '0;

      if (step_valid) begin
         case (step_item.cmd)
            CMD_TICK: begin
               if (enabled_ff) begin
                  if (!bit_done) begin
                     prescale_in = sum_sat;
                  end else begin
                     prescale_in = sum_sat - {1'b0, divisor_ff};
                     // advance bit counters, saturating
                     if (tx_en_ff && tx_cnt_ff != 8'hFF) begin
                        tx_cnt_v = tx_cnt_ff + 8'd1;
                     end
                     if (rx_en_ff && rx_cnt_ff != 8'hFF) begin
                        rx_cnt_v = rx_cnt_ff + 8'd1;
                     end
                     tx_cnt_in = tx_cnt_v;
                     // finish transmit frame, restart from buffer if full and transmit is enabled
                     if (tx_busy_ff && tx_cnt_v >= FRAME_LIMIT) begin
                        tx_busy_in           = 1'b0;
                        step_result.tx_valid = 1'b1;
                        step_result.tx_byte  = tx_shift_ff;
                        tx_cnt_in            = tx_cnt_v - FRAME_LIMIT;
                        if (tx_full_ff) begin
                           if (tx_en_ff) begin
                              tx_shift_in = tx_buf_ff;
                              tx_full_in  = 1'b0;
                              tx_busy_in  = 1'b1;
                              tx_cnt_in   = 8'd0;
                              regfile_in[SR_IDX][SR_TXE_BIT] = 1'b0;
                           end
                        end else begin
                           regfile_in[SR_IDX][SR_TXE_BIT] = 1'b1;
                           regfile_in[SR_IDX][SR_TC_BIT]  = 1'b1;
                        end
                     end
                     // start receive frame on a pending host byte
                     if (rx_en_ff && !rx_busy_ff && host_pend_ff) begin
                        rx_busy_v = 1'b1;
                        rx_cnt_v  = 8'd0;
                     end
                     // finish receive frame and deliver into DR
                     if (rx_busy_v && rx_cnt_v >= FRAME_LIMIT) begin
                        if (host_pend_ff) begin
                           regfile_in[DR_IDX] = host_byte_ff;
                           regfile_in[SR_IDX][SR_RXNE_BIT] = 1'b1;
                           host_pend_in = 1'b0;
                        end
                        rx_busy_v = 1'b0;
                        rx_cnt_v  = rx_cnt_v - FRAME_LIMIT;
                     end
                     rx_busy_in = rx_busy_v;
                     rx_cnt_in  = rx_cnt_v;
                  end
               end
            end
            CMD_WRITE: begin
               if (addr_hit) begin
                  regfile_in[addr_idx] = step_item.write_data;
                  // rebuild baud divisor
                  if (step_item.reg_addr == ADDR_BRR1 || step_item.reg_addr == ADDR_BRR2) begin
                     if (step_item.reg_addr == ADDR_BRR1) begin
                        baud_lo = step_item.write_data;
                     end else begin
                        baud_hi = step_item.write_data;
                     end
                     divisor_in  = {baud_hi[7:4], baud_lo, baud_hi[3:0]};
                     prescale_in = 17'd0;
                  end
                  // reload enables and clear frame state
                  if (step_item.reg_addr == ADDR_CR1 || step_item.reg_addr == ADDR_CR2) begin
                     if (step_item.reg_addr == ADDR_CR1) begin
                        ctrl1 = step_item.write_data;
                     end else begin
                        ctrl2 = step_item.write_data;
                     end
                     enabled_in = !ctrl1[CR1_DISABLE_BIT];
                     tx_en_in   = ctrl2[CR2_TEN_BIT];
                     rx_en_in   = ctrl2[CR2_REN_BIT];
                     tx_cnt_in  = 8'd0;
                     rx_cnt_in  = 8'd0;
                     rx_busy_in = 1'b0;
                     tx_full_in = 1'b0;
                  end
                  // fill transmit buffer, start a frame when idle
                  if (step_item.reg_addr == ADDR_DR) begin
                     tx_buf_in  = step_item.write_data;
                     tx_full_in = 1'b1;
                     if (!tx_busy_ff && tx_en_ff) begin
                        tx_shift_in = step_item.write_data;
                        tx_full_in  = 1'b0;
                        tx_busy_in  = 1'b1;
                        tx_cnt_in   = 8'd0;
                        regfile_in[SR_IDX][SR_TXE_BIT] = 1'b0;
                     end
                  end
               end
            end
            CMD_READ: begin
               if (addr_hit) begin
                  step_result.read_data = regfile_ff[addr_idx];
               end
            end
            CMD_HOST: begin
               // drop the byte if one is already pending
               if (!host_pend_ff) begin
                  host_pend_in = 1'b1;
                  host_byte_in = step_item.host_byte;
               end
            end
            default: begin
            end
         endcase
      end

      step_result.status = regfile_in[SR_IDX];
   end

   // Hold state, advance on each beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            regfile_ff[i] <= 8'd0;
         end
         divisor_ff   <= 16'd0;
         prescale_ff  <= 17'd0;
         enabled_ff   <= 1'b1;
         tx_en_ff     <= 1'b0;
         rx_en_ff     <= 1'b0;
         tx_cnt_ff    <= 8'd0;
         rx_cnt_ff    <= 8'd0;
         tx_busy_ff   <= 1'b0;
         rx_busy_ff   <= 1'b0;
         tx_full_ff   <= 1'b0;
         tx_buf_ff    <= 8'd0;
         tx_shift_ff  <= 8'd0;
         host_pend_ff <= 1'b0;
         host_byte_ff <= 8'd0;
      end else begin
         regfile_ff   <= regfile_in;
         divisor_ff   <= divisor_in;
         prescale_ff  <= prescale_in;
         enabled_ff   <= enabled_in;
         tx_en_ff     <= tx_en_in;
         rx_en_ff     <= rx_en_in;
         tx_cnt_ff    <= tx_cnt_in;
         rx_cnt_ff    <= rx_cnt_in;
         tx_busy_ff   <= tx_busy_in;
         rx_busy_ff   <= rx_busy_in;
         tx_full_ff   <= tx_full_in;
         tx_buf_ff    <= tx_buf_in;
         tx_shift_ff  <= tx_shift_in;
         host_pend_ff <= host_pend_in;
         host_byte_ff <= host_byte_in;
      end
   end

endmodule

// ===== dv/tb_uart_register_model.sv =====
// ----------------------------------------------------------------------------
// tb_uart_register_model
// Self-checking bench for the UART register model. A shadow of the register
// file, prescaler and frame state predicts every response beat; a checker
// compares each accepted response field by field in order. Directed beats
// cover bounds, frames, receive and disable paths, then long random traffic
// runs with random gaps on the request side and stalls on the response side.
// ----------------------------------------------------------------------------
module tb_uart_register_model;
   import urm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_LEN = 10;
   localparam int REG_N     = 12;

   localparam logic [3:0] ADDR_BEYOND = 4'd15;
   localparam logic [7:0] CR1_OFF     = 8'd1 << CR1_DISABLE_BIT;
   localparam logic [7:0] CR2_RX_ONLY = 8'd1 << CR2_REN_BIT;
   localparam logic [7:0] CR2_BOTH    = (8'd1 << CR2_TEN_BIT) | CR2_RX_ONLY;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_payload;

   bit gaps_on;
   bit stalls_on;
   int error_count = 0;

   // Responses predicted for accepted beats, oldest first
   rsp_item_type uart_rsp_q[$];

   // Shadow of the block's state
   logic [7:0]  sh_regs [REG_N] = '{default: 8'h00};
   logic [15:0] sh_divisor      = '0;
   logic [16:0] sh_prescale     = '0;
   bit          sh_enabled      = 1'b1;
   bit          sh_tx_en        = 1'b0;
   bit          sh_rx_en        = 1'b0;
   logic [7:0]  sh_tx_bits      = '0;
   logic [7:0]  sh_rx_bits      = '0;
   bit          sh_tx_busy      = 1'b0;
   bit          sh_rx_busy      = 1'b0;
   bit          sh_tx_full      = 1'b0;
   logic [7:0]  sh_tx_buf       = '0;
   logic [7:0]  sh_tx_shift     = '0;
   bit          sh_host_pending = 1'b0;
   logic [7:0]  sh_host_byte    = '0;

   uart_register_model #(
      .FRAME_BITS(FRAME_LEN),
      .REG_COUNT (REG_N)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   initial forever #5 clock = ~clock;

   // Run limit
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Mostly short idle stretches, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 8);
      return $urandom_range(15, 40);
   endfunction

   // Move the buffered byte into the shifter if the transmitter is on
   function automatic void sh_start_tx();
      if (sh_tx_en) begin
         sh_tx_shift = sh_tx_buf;
         sh_tx_full  = 1'b0;
         sh_tx_busy  = 1'b1;
         sh_tx_bits  = '0;
         sh_regs[ADDR_SR][SR_TXE_BIT] = 1'b0;
      end
   endfunction

   // Apply one beat to the shadow and return the response it produces
   function automatic rsp_item_type uart_shadow_step(req_item_type beat);
      rsp_item_type rsp;
      logic [17:0]  sum;
      rsp = '0;
      case (beat.cmd)
         CMD_TICK: begin
            if (sh_enabled) begin
               sum = {1'b0, sh_prescale} + 18'(beat.tick_cycles);
               if (sum > 18'(PRESCALE_MAX)) sum = 18'(PRESCALE_MAX);
               if (sum < 18'(sh_divisor)) begin
                  sh_prescale = sum[16:0];
               end else begin
                  // one bit-time passes
                  sh_prescale = 17'(sum - 18'(sh_divisor));
                  if (sh_tx_en && sh_tx_bits != 8'hFF) sh_tx_bits = sh_tx_bits + 8'd1;
                  if (sh_rx_en && sh_rx_bits != 8'hFF) sh_rx_bits = sh_rx_bits + 8'd1;
                  if (sh_tx_busy && sh_tx_bits >= FRAME_LEN) begin
                     sh_tx_busy   = 1'b0;
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = sh_tx_shift;
                     sh_tx_bits   = 8'(sh_tx_bits - FRAME_LEN);
                     if (sh_tx_full) begin
                        sh_start_tx();
                     end else begin
                        sh_regs[ADDR_SR][SR_TXE_BIT] = 1'b1;
                        sh_regs[ADDR_SR][SR_TC_BIT]  = 1'b1;
                     end
                  end
                  if (sh_rx_en && !sh_rx_busy && sh_host_pending) begin
                     sh_rx_busy = 1'b1;
                     sh_rx_bits = '0;
                  end
                  if (sh_rx_busy && sh_rx_bits >= FRAME_LEN) begin
                     if (sh_host_pending) begin
                        sh_regs[ADDR_DR] = sh_host_byte;
                        sh_regs[ADDR_SR][SR_RXNE_BIT] = 1'b1;
                        sh_host_pending = 1'b0;
                     end
                     sh_rx_busy = 1'b0;
                     sh_rx_bits = 8'(sh_rx_bits - FRAME_LEN);
                  end
               end
            end
         end
         CMD_WRITE: begin
            if (beat.reg_addr < REG_N) begin
               sh_regs[beat.reg_addr] = beat.write_data;
               case (beat.reg_addr)
                  ADDR_BRR1, ADDR_BRR2: begin
                     sh_divisor  = {sh_regs[ADDR_BRR2][7:4], sh_regs[ADDR_BRR1],
                                    sh_regs[ADDR_BRR2][3:0]};
                     sh_prescale = '0;
                  end
                  ADDR_CR1, ADDR_CR2: begin
                     sh_enabled = !sh_regs[ADDR_CR1][CR1_DISABLE_BIT];
                     sh_tx_en   = sh_regs[ADDR_CR2][CR2_TEN_BIT];
                     sh_rx_en   = sh_regs[ADDR_CR2][CR2_REN_BIT];
                     sh_tx_bits = '0;
                     sh_rx_bits = '0;
                     sh_rx_busy = 1'b0;
                     sh_tx_full = 1'b0;
                  end
                  ADDR_DR: begin
                     sh_tx_buf  = beat.write_data;
                     sh_tx_full = 1'b1;
                     if (!sh_tx_busy) sh_start_tx();
                  end
                  default: ;
               endcase
            end
         end
         CMD_READ: begin
            rsp.read_data = (beat.reg_addr < REG_N) ? sh_regs[beat.reg_addr] : 8'h00;
         end
         CMD_HOST: begin
            // drop the new byte while one is still pending
            if (!sh_host_pending) begin
               sh_host_pending = 1'b1;
               sh_host_byte    = beat.host_byte;
            end
         end
         default: ;
      endcase
      rsp.status = sh_regs[ADDR_SR];
      return rsp;
   endfunction

   // Send one beat; fields the command does not use carry random noise
   task automatic send_op(cmd_type op, logic [3:0] addr, logic [7:0] value);
      req_item_type beat;
      int           gap;
      beat.cmd         = op;
      beat.reg_addr    = addr;
      beat.write_data  = (op == CMD_WRITE) ? value : 8'($urandom);
      beat.tick_cycles = (op == CMD_TICK) ? value : 8'($urandom_range(1, 255));
      beat.host_byte   = (op == CMD_HOST) ? value : 8'($urandom);
      gap = (gaps_on && $urandom_range(0, 99) < 35) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      uart_rsp_q.push_back(uart_shadow_step(beat));
   endtask

   // Hold off the sender until every predicted response has come back
   task automatic drain_rsp();
      req_valid <= 1'b0;
      do @(posedge clock); while (uart_rsp_q.size() != 0);
   endtask

   // One random beat; fast_ticks keeps the prescaler near its ceiling
   task automatic send_traffic(int tick_pct, bit fast_ticks);
      int         r;
      logic [3:0] a;
      logic [7:0] cyc;
      r = $urandom_range(0, 99);
      if (r < tick_pct) begin
         if (fast_ticks)
            cyc = ($urandom_range(0, 3) != 0) ? 8'hFF : 8'($urandom_range(200, 255));
         else
            cyc = $urandom_range(0, 1) ? 8'($urandom_range(1, 15)) : 8'($urandom_range(1, 255));
         send_op(CMD_TICK, 4'($urandom), cyc);
      end else begin
         r = $urandom_range(0, 99);
         if (r < 30) begin
            send_op(CMD_WRITE, ADDR_DR, 8'($urandom));
         end else if (r < 55) begin
            send_op(CMD_HOST, 4'($urandom), 8'($urandom));
         end else if (r < 85) begin
            send_op(CMD_READ, 4'($urandom), 8'h00);
         end else begin
            // keep the divisor and prescaler untouched during fast runs
            a = fast_ticks ? 4'($urandom_range(ADDR_CR2 + 1, 15)) : 4'($urandom);
            if (fast_ticks && $urandom_range(0, 3) == 0) a = ADDR_SR;
            send_op(CMD_WRITE, a, 8'($urandom));
         end
      end
   endtask

   task automatic test_reset_and_bounds();
      send_op(CMD_READ, ADDR_SR, 8'h00);
      send_op(CMD_WRITE, ADDR_BEYOND, 8'hFF);
      send_op(CMD_READ, ADDR_BEYOND, 8'h00);
      send_op(CMD_WRITE, ADDR_SR, 8'h1F);
   endtask

   // Zero divisor: every tick is a bit-time
   task automatic test_frame_and_receive();
      int i;
      send_op(CMD_WRITE, ADDR_BRR2, 8'h00);
      send_op(CMD_WRITE, ADDR_CR2, CR2_RX_ONLY);
      send_op(CMD_WRITE, ADDR_DR, 8'h77);
      send_op(CMD_WRITE, ADDR_CR2, CR2_BOTH);
      send_op(CMD_WRITE, ADDR_DR, 8'hA5);
      send_op(CMD_WRITE, ADDR_DR, 8'h5A);
      send_op(CMD_HOST, 4'($urandom), 8'h3C);
      send_op(CMD_HOST, 4'($urandom), 8'hC3);
      for (i = 0; i < 11; i++) send_op(CMD_TICK, 4'($urandom), (i % 2) ? 8'd1 : 8'd255);
      send_op(CMD_READ, ADDR_DR, 8'h00);
   endtask

   task automatic test_disable_paths();
      send_op(CMD_WRITE, ADDR_CR1, CR1_OFF);
      send_op(CMD_TICK, 4'($urandom), 8'd255);
      send_op(CMD_WRITE, ADDR_CR1, 8'h00);
   endtask

   // Long run at zero divisor so the prescale sum reaches its ceiling
   task automatic test_prescale_saturation();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      drain_rsp();
      send_op(CMD_WRITE, ADDR_BRR1, 8'h00);
      send_op(CMD_WRITE, ADDR_BRR2, 8'h00);
      send_op(CMD_WRITE, ADDR_CR1, 8'h00);
      send_op(CMD_WRITE, ADDR_CR2, CR2_BOTH);
      repeat (700) send_traffic(80, 1'b1);
   endtask

   // Episodes: set up divisor and controls, then mixed traffic
   task automatic test_random_traffic();
      int sent;
      int len;
      int ep;
      bit quiet;
      sent = 0;
      ep   = 0;
      while (sent < 400) begin
         drain_rsp();
         quiet     = (ep == 3);
         gaps_on   = !quiet;
         stalls_on = !quiet;
         send_op(CMD_WRITE, ADDR_BRR1,
                 ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 2)) : 8'($urandom));
         send_op(CMD_WRITE, ADDR_BRR2,
                 ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 15)) : 8'($urandom));
         send_op(CMD_WRITE, ADDR_CR1,
                 ($urandom_range(0, 99) < 85) ? (8'($urandom) & ~CR1_OFF) : 8'($urandom));
         send_op(CMD_WRITE, ADDR_CR2,
                 ($urandom_range(0, 99) < 85) ? (8'($urandom) | CR2_BOTH) : 8'($urandom));
         len = $urandom_range(30, 60);
         repeat (len) send_traffic(50, 1'b0);
         sent += len + 4;
         ep++;
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   // Let outstanding responses arrive, then report
   task automatic finish_run();
      int n;
      req_valid <= 1'b0;
      stalls_on = 1'b0;
      for (n = 0; n < 20000 && uart_rsp_q.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (uart_rsp_q.size() != 0) begin
         error_count++;
         $display("%t: %0d responses never arrived", $time, uart_rsp_q.size());
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_and_bounds();
      test_frame_and_receive();
      test_disable_paths();
      test_prescale_saturation();
      test_random_traffic();
      finish_run();
   end

   // Stall the response side in random bursts
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 99) < 20) begin
            rsp_stall <= 1'b1;
            repeat (idle_len()) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%t: %s expected %h, got %h", $time, name, want, got);
      end
   endfunction

   // Compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (uart_rsp_q.size() == 0) begin
            error_count++;
            $display("%t: response %h with none outstanding", $time, rsp_payload);
         end else begin
            want = uart_rsp_q.pop_front();
            check_field("read_data", want.read_data, rsp_payload.read_data);
            check_field("tx_valid", 8'(want.tx_valid), 8'(rsp_payload.tx_valid));
            check_field("tx_byte", want.tx_byte, rsp_payload.tx_byte);
            check_field("status", want.status, rsp_payload.status);
         end
      end
   end

endmodule
